[rtl/core/ifdf_pkg.sv]
// Package for the interpolate-by-two FIR decimate-by-two filter.
// Holds sizes, derived widths and the command and status structs that join
// the controller to the datapath. It depends on nothing else.
`default_nettype none

package ifdf_pkg;

  // Sizes of the stores and the coefficient format.
  localparam int HISTORY_DEPTH  = 1024;
  localparam int TAPS           = 1801;
  localparam int COEF_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 22;

  // Fixed field widths.
  localparam int SAMPLE_W    = 16;
  localparam int COEF_IDX_W  = 11;

  // Derived widths.
  localparam int HIST_AW     = $clog2(HISTORY_DEPTH);
  localparam int TAP_W       = $clog2(TAPS);
  localparam int WARMUP_LEN  = TAPS / 2;
  localparam int WARMUP_W    = $clog2(WARMUP_LEN + 1);
  localparam int PT_W        = SAMPLE_W + 1;
  localparam int PROD_W      = COEF_WIDTH + PT_W;
  localparam int ACC_W       = PROD_W + $clog2(TAPS);
  localparam int RES_SHIFT   = COEF_FRAC_BITS + 1;

  // Request codes on req_type.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef struct packed {
    logic             accept_coef;
    logic             accept_sample;
    logic             issue;
    logic [TAP_W-1:0] tap_idx;
    logic             finish;
    logic             load_out;
  } ifdf_cmd_t;

  typedef struct packed {
    logic warm;
    logic pipe_busy;
    logic out_free;
  } ifdf_status_t;

endpackage

`default_nettype wire

[rtl/core/ifdf_ctrl.sv]
// Controller of the interpolate-by-two FIR decimate-by-two filter.
// Sequences accept, tap walk, pipeline drain and result hand-off.
// Depends on ifdf_pkg.
`default_nettype none

module ifdf_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  wire                         req_type_i,
  output logic                        in_ready_o,
  output ifdf_pkg::ifdf_cmd_t         cmd_o,
  input  wire ifdf_pkg::ifdf_status_t status_i
);
  import ifdf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [TAP_W-1:0] tap_q;
  logic             accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o               = '0;
    cmd_o.accept_coef   = accept && (req_type_i == REQ_COEF);
    cmd_o.accept_sample = accept && (req_type_i == REQ_SAMPLE);
    cmd_o.issue         = (state_q == ST_RUN);
    cmd_o.tap_idx       = tap_q;
    cmd_o.finish        = (state_q == ST_DRAIN) && !status_i.pipe_busy;
    cmd_o.load_out      = (state_q == ST_EMIT) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          tap_q <= '0;
          if (cmd_o.accept_sample) begin
            state_q <= status_i.warm ? ST_EMIT : ST_RUN;
          end
        end
        ST_RUN: begin
          if (tap_q == TAP_W'(TAPS - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/ifdf_datapath.sv]
// Datapath of the interpolate-by-two FIR decimate-by-two filter: sample
// history, tap store, multiply-accumulate pipeline and output register.
// Depends on ifdf_pkg; driven by ifdf_ctrl.
`default_nettype none

module ifdf_datapath (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire ifdf_pkg::ifdf_cmd_t                  cmd_i,
  output ifdf_pkg::ifdf_status_t                    status_o,
  input  wire signed [ifdf_pkg::SAMPLE_W-1:0]       sample_i,
  input  wire        [ifdf_pkg::COEF_IDX_W-1:0]     coef_index_i,
  input  wire signed [ifdf_pkg::COEF_WIDTH-1:0]     coef_value_i,
  input  wire                                       out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [ifdf_pkg::SAMPLE_W-1:0]      filtered_sample_o,
  output logic                                      was_raw_o
);
  import ifdf_pkg::*;

  localparam int HS_W = HIST_AW + 2;

  logic signed [SAMPLE_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic signed [COEF_WIDTH-1:0] tap_mem  [TAPS];

  logic [HIST_AW-1:0]  wp_q, cur_q;
  logic [WARMUP_W-1:0] warmup_q;
  logic                filtering_q;

  logic                         v1_q, v2_q, v3_q;
  logic                         odd1_q;
  logic signed [SAMPLE_W-1:0]   hist_rd_q, hold_q;
  logic signed [COEF_WIDTH-1:0] coef_rd_q, coef2_q;
  logic signed [PT_W-1:0]       pt_q, pt_d;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      acc_q, acc_biased;

  logic signed [SAMPLE_W-1:0]   res_q, res_final;
  logic                         res_raw_q;
  logic                         out_valid_q, out_raw_q;
  logic signed [SAMPLE_W-1:0]   out_data_q;

  logic [TAP_W-1:0]   back;
  logic [HS_W-1:0]    hist_sum;
  logic [HIST_AW-1:0] hist_addr;

  assign status_o.warm      = !filtering_q && (warmup_q < WARMUP_W'(WARMUP_LEN));
  assign status_o.pipe_busy = v1_q || v2_q || v3_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Tap j reads the sample (j+1)/2 places back: an even tap doubles it, an
  // odd tap adds it to the sample that the even tap before it read.
  assign back      = TAP_W'(({1'b0, cmd_i.tap_idx} + 1'b1) >> 1);
  assign hist_sum  = HS_W'(cur_q) + HS_W'(HISTORY_DEPTH) - HS_W'(back);
  assign hist_addr = (hist_sum >= HS_W'(HISTORY_DEPTH)) ?
                     HIST_AW'(hist_sum - HS_W'(HISTORY_DEPTH)) : HIST_AW'(hist_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_sample) begin
      hist_mem[wp_q] <= sample_i;
    end
    if (cmd_i.issue) begin
      hist_rd_q <= hist_mem[hist_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_coef && (coef_index_i < COEF_IDX_W'(TAPS))) begin
      tap_mem[coef_index_i[TAP_W-1:0]] <= coef_value_i;
    end
    if (cmd_i.issue) begin
      coef_rd_q <= tap_mem[cmd_i.tap_idx];
    end
  end

  always_comb begin
    if (odd1_q) begin
      pt_d = PT_W'(hold_q) + PT_W'(hist_rd_q);
    end else begin
      pt_d = {hist_rd_q, 1'b0};
    end
  end

  // Truncation toward zero: a negative sum is biased up before the shift.
  assign acc_biased = acc_q[ACC_W-1] ?
                      acc_q + {{(ACC_W-RES_SHIFT){1'b0}}, {RES_SHIFT{1'b1}}} : acc_q;
  assign res_final  = acc_biased[RES_SHIFT +: SAMPLE_W];

  // Payload registers of the pipeline.
  always_ff @(posedge clk_i) begin
    odd1_q <= cmd_i.tap_idx[0];
    if (v1_q) begin
      pt_q    <= pt_d;
      coef2_q <= coef_rd_q;
      if (!odd1_q) begin
        hold_q <= hist_rd_q;
      end
    end
    if (v2_q) begin
      prod_q <= coef2_q * pt_q;
    end
    if (cmd_i.accept_sample) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.accept_sample && status_o.warm) begin
      res_q <= sample_i;
    end else if (cmd_i.finish) begin
      res_q <= res_final;
    end
    if (cmd_i.load_out) begin
      out_data_q <= res_q;
      out_raw_q  <= res_raw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      cur_q       <= '0;
      warmup_q    <= '0;
      filtering_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_raw_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.accept_sample) begin
        cur_q     <= wp_q;
        wp_q      <= (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        res_raw_q <= status_o.warm;
        if (status_o.warm) begin
          warmup_q <= warmup_q + 1'b1;
        end else begin
          filtering_q <= 1'b1;
        end
      end else if (cmd_i.finish) begin
        res_raw_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;
  assign was_raw_o         = out_raw_q;

endmodule

`default_nettype wire

[rtl/core/interpolate_fir_decimate_filter.sv]
// Top level of the interpolate-by-two FIR decimate-by-two filter.
// Joins ifdf_ctrl and ifdf_datapath; depends on ifdf_pkg.
`default_nettype none

// The block filters 16-bit ECG samples with a TAPS-tap FIR (1801 by default)
// run over the sample stream upsampled by two with linear interpolation, and
// gives one result per sample. The first TAPS/2 samples pass through raw with
// was_raw set. A coefficient write (req_type 1) gives no transaction on the
// output; a raw sample is passed to the output register unfiltered. For a
// filtered sample one shared multiply-accumulate walks the taps one per cycle,
// reading the tap store and the history memory once per tap, then its
// four-stage pipeline drains. One sample is worked on at a time; the finished
// result sits in an output register, so the next transaction is taken while it
// waits. Taps and history need no clearing: a filtered sample must only follow
// writes of all taps.
module interpolate_fir_decimate_filter (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire                                   req_type_i,
  input  wire signed [ifdf_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire        [ifdf_pkg::COEF_IDX_W-1:0] coef_index_i,
  input  wire signed [ifdf_pkg::COEF_WIDTH-1:0] coef_value_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [ifdf_pkg::SAMPLE_W-1:0]  filtered_sample_o,
  output logic                                  was_raw_o
);
  import ifdf_pkg::*;

  ifdf_cmd_t    cmd;
  ifdf_status_t status;

  ifdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  ifdf_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .sample_i          (sample_i),
    .coef_index_i      (coef_index_i),
    .coef_value_i      (coef_value_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .filtered_sample_o (filtered_sample_o),
    .was_raw_o         (was_raw_o)
  );

  // When the block is ready, the multiply-accumulate pipeline is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status.pipe_busy)
    else $error("pipeline still busy while accepting input");

  // A coefficient write leaves the block ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_COEF)) |=> in_ready_o)
    else $error("coefficient write did not return to idle");

  // A sample past warm-up starts the tap walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept_sample && !status.warm) |=> (cmd.issue && !in_ready_o))
    else $error("filtered sample did not start the tap walk");

endmodule

`default_nettype wire
